// ===== src/assert_macros.svh =====
// Assertion macros shared by the rotation engine RTL.
// Every assertion samples on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check.
`define IMROT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define IMROT_ASSERT_NEVER(label, expr, msg) \
  `IMROT_ASSERT(label, !(expr), msg)

`endif

// ===== src/imrot_pkg.sv =====
package imrot_pkg;

  // Default sizing
  localparam int unsigned MAX_SIDE_DEF   = 256;
  localparam int unsigned PIXEL_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned SIDE_CFG_BITS = 9;
  localparam int unsigned PIX_FIELD_BITS = 32;

  // Configuration port
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROTATE_LEFT  = 2'd2;

  // Register reset values
  localparam logic [SIDE_CFG_BITS-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [SIDE_CFG_BITS-1:0] IMAGE_HEIGHT_RST = 9'd256;
  localparam logic                     ROTATE_LEFT_RST  = 1'b0;

  // Item action codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [PIX_FIELD_BITS-1:0] pixel_in;
    logic                      start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [PIX_FIELD_BITS-1:0] pixel_out;
    logic                      last_of_image;
    logic                      not_ready;
  } out_item_t;

  typedef struct packed {
    logic [SIDE_CFG_BITS-1:0] image_width;
    logic [SIDE_CFG_BITS-1:0] image_height;
    logic                     rotate_left;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture the accepted transaction
    logic store;     // write pixel, bump stored count
    logic advance;   // form read address terms, step read counters
    logic ram_re;    // read the pixel store
    logic load_nr;   // load a not-ready result
    logic load_pix;  // load the pixel result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic loaded;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/imrot_ram.sv =====
module imrot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/imrot_cfg.sv =====
module imrot_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [imrot_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [imrot_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [imrot_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output imrot_pkg::cfg_t                    cfg_o
);

  imrot_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        imrot_pkg::REG_IMAGE_WIDTH:
          cfg_d.image_width = pwdata[imrot_pkg::SIDE_CFG_BITS-1:0];
        imrot_pkg::REG_IMAGE_HEIGHT:
          cfg_d.image_height = pwdata[imrot_pkg::SIDE_CFG_BITS-1:0];
        imrot_pkg::REG_ROTATE_LEFT:
          cfg_d.rotate_left = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= imrot_pkg::IMAGE_WIDTH_RST;
      cfg_q.image_height <= imrot_pkg::IMAGE_HEIGHT_RST;
      cfg_q.rotate_left  <= imrot_pkg::ROTATE_LEFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode
  always_comb begin
    unique case (paddr[3:2])
      imrot_pkg::REG_IMAGE_WIDTH:
        prdata = imrot_pkg::APB_DATA_BITS'(cfg_q.image_width);
      imrot_pkg::REG_IMAGE_HEIGHT:
        prdata = imrot_pkg::APB_DATA_BITS'(cfg_q.image_height);
      imrot_pkg::REG_ROTATE_LEFT:
        prdata = imrot_pkg::APB_DATA_BITS'(cfg_q.rotate_left);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/imrot_ctrl.sv =====
`include "assert_macros.svh"

module imrot_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  imrot_pkg::dp_status_t status_i,
  output imrot_pkg::dp_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] S_EXEC = 2'd1;  // store, load a not-ready result, or form read address terms
  localparam logic [1:0] S_ADDR = 2'd2;  // address the pixel store
  localparam logic [1:0] S_READ = 2'd3;  // pixel data back, load result

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status_i.is_read) begin
          cmd_o.store = 1'b1;
          state_d     = S_IDLE;
        end else if (!status_i.loaded) begin
          // wait for room in the output register
          if (status_i.out_free) begin
            cmd_o.load_nr = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        if (status_i.out_free) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath actions are exclusive
  `IMROT_ASSERT(a_cmd_exclusive, $onehot0({cmd_o.store, cmd_o.advance, cmd_o.ram_re, cmd_o.load_nr, cmd_o.load_pix}), "overlapping datapath commands")
  // A result is loaded only into a free output register
  `IMROT_ASSERT(a_load_when_free, (cmd_o.load_nr || cmd_o.load_pix) |-> status_i.out_free, "result loaded over a pending one")
  // Forming a read address is always followed by the pixel store read
  `IMROT_ASSERT(a_read_follows, cmd_o.advance |=> cmd_o.ram_re, "read sequence broken")

endmodule

// ===== src/imrot_dp.sv =====
`include "assert_macros.svh"

module imrot_dp #(
  parameter int unsigned MAX_SIDE   = imrot_pkg::MAX_SIDE_DEF,
  parameter int unsigned PIXEL_BITS = imrot_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imrot_pkg::cfg_t       cfg_i,
  input  imrot_pkg::in_item_t   in_data_i,
  input  imrot_pkg::dp_cmd_t    cmd_i,
  output imrot_pkg::dp_status_t status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output imrot_pkg::out_item_t  out_data_o
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);        // store address
  localparam int unsigned TW    = AW + 1;               // pixel count, up to DEPTH
  localparam int unsigned CW    = $clog2(MAX_SIDE);     // row / column index
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1); // side length
  localparam int unsigned EW    = (SW > imrot_pkg::SIDE_CFG_BITS) ? SW :
                                  imrot_pkg::SIDE_CFG_BITS;
  localparam int unsigned PW    = CW + SW;              // product width

  // Clamped image sides
  logic [SW-1:0] w_c, h_c;
  logic [EW-1:0] w_ext, h_ext;

  assign w_ext = EW'(cfg_i.image_width);
  assign h_ext = EW'(cfg_i.image_height);

  always_comb begin
    if (w_ext == '0) begin
      w_c = SW'(1);
    end else if (w_ext > EW'(MAX_SIDE)) begin
      w_c = SW'(MAX_SIDE);
    end else begin
      w_c = w_ext[SW-1:0];
    end
    if (h_ext == '0) begin
      h_c = SW'(1);
    end else if (h_ext > EW'(MAX_SIDE)) begin
      h_c = SW'(MAX_SIDE);
    end else begin
      h_c = h_ext[SW-1:0];
    end
  end

  // Image size in pixels, registered off the multiplier
  logic [2*SW-1:0] total_full;
  logic [TW-1:0]   total_q;

  assign total_full = (2*SW)'(w_c) * (2*SW)'(h_c);

  always_ff @(posedge clk_i) begin
    total_q <= total_full[TW-1:0];
  end

  // Captured transaction
  imrot_pkg::in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
  end

  // Counters
  logic [TW-1:0] stored_count_q, stored_count_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [CW-1:0] out_row_q, out_row_d;

  // Store path
  logic [TW-1:0] count_base;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;

  assign count_base = item_q.start_of_image ? '0 : stored_count_q;
  assign ram_we     = cmd_i.store && (count_base < total_q);
  assign ram_waddr  = count_base[AW-1:0];

  // Read address terms
  logic          wrap;
  logic [CW-1:0] row_e, col_e;
  logic [CW-1:0] mul_a, addend_d;
  logic [SW-1:0] w_m1_col, h_m1_row;
  logic [PW-1:0] prod_full;
  logic          last_d;
  logic [SW-1:0] row_inc, col_inc;

  assign wrap  = (SW'(out_col_q) >= w_c) || (SW'(out_row_q) >= h_c);
  assign row_e = wrap ? '0 : out_row_q;
  assign col_e = wrap ? '0 : out_col_q;

  assign w_m1_col = w_c - SW'(1) - SW'(col_e);
  assign h_m1_row = h_c - SW'(1) - SW'(row_e);

  always_comb begin
    if (cfg_i.rotate_left) begin
      mul_a    = row_e;
      addend_d = w_m1_col[CW-1:0];
    end else begin
      mul_a    = h_m1_row[CW-1:0];
      addend_d = col_e;
    end
  end

  assign prod_full = PW'(mul_a) * PW'(w_c);
  assign last_d    = (SW'(col_e) == w_c - SW'(1)) && (SW'(row_e) == h_c - SW'(1));
  assign row_inc   = SW'(row_e) + SW'(1);
  assign col_inc   = SW'(col_e) + SW'(1);

  // Counter next state
  always_comb begin
    stored_count_d = stored_count_q;
    out_col_d      = out_col_q;
    out_row_d      = out_row_q;
    if (cmd_i.store) begin
      if (item_q.start_of_image) begin
        out_col_d = '0;
        out_row_d = '0;
      end
      stored_count_d = ram_we ? count_base + TW'(1) : count_base;
    end
    if (cmd_i.advance) begin
      if (row_inc >= h_c) begin
        out_row_d = '0;
        out_col_d = (col_inc >= w_c) ? '0 : col_inc[CW-1:0];
      end else begin
        out_row_d = row_inc[CW-1:0];
        out_col_d = col_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count_q <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
    end else begin
      stored_count_q <= stored_count_d;
      out_col_q      <= out_col_d;
      out_row_q      <= out_row_d;
    end
  end

  // Address stage registers
  logic [AW-1:0] prod_q;
  logic [CW-1:0] addend_q;
  logic          last_q;
  logic [AW-1:0] ram_raddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      prod_q   <= prod_full[AW-1:0];
      addend_q <= addend_d;
      last_q   <= last_d;
    end
  end

  assign ram_raddr = prod_q + AW'(addend_q);

  // Pixel store
  logic [PIXEL_BITS-1:0] ram_rdata;

  imrot_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_q.pixel_in[PIXEL_BITS-1:0]),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  logic                 out_valid_q, out_valid_d;
  imrot_pkg::out_item_t out_data_q, out_data_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_nr) begin
      out_valid_d              = 1'b1;
      out_data_d.pixel_out     = '0;
      out_data_d.last_of_image = 1'b0;
      out_data_d.not_ready     = 1'b1;
    end else if (cmd_i.load_pix) begin
      out_valid_d              = 1'b1;
      out_data_d.pixel_out     = imrot_pkg::PIX_FIELD_BITS'(ram_rdata);
      out_data_d.last_of_image = last_q;
      out_data_d.not_ready     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status
  assign status_o.is_read  = (item_q.action == imrot_pkg::ACT_READ);
  assign status_o.loaded   = (stored_count_q >= total_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Read counters stay inside the image after a step
  `IMROT_ASSERT(a_counters_in_range, cmd_i.advance |=> ((SW'(out_row_q) < h_c) && (SW'(out_col_q) < w_c)), "read counter outside image")
  // A pixel write bumps the stored count by one
  `IMROT_ASSERT(a_store_count, ram_we |=> (stored_count_q == TW'($past(count_base)) + TW'(1)), "stored count out of step")
  // Stores and pixel reads never share a cycle
  `IMROT_ASSERT_NEVER(a_no_rw_overlap, ram_we && cmd_i.ram_re, "store write during pixel read")

endmodule

// ===== src/image_rotate_90.sv =====
// Sequence: a store transaction writes the captured pixel if the image has room; a pixel
// read passes index multiply, store address and output load in that order; a
// not-ready read loads its result once the output register is free.
// Throughput: one transaction at a time; reads wait while the output register stalls.
// Reset: asynchronous, clears counters, control state, configuration and output valid;
// data registers and the pixel store are kept.
`include "assert_macros.svh"

module image_rotate_90 #(
  parameter int unsigned MAX_SIDE   = imrot_pkg::MAX_SIDE_DEF,
  parameter int unsigned PIXEL_BITS = imrot_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  imrot_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output imrot_pkg::out_item_t                out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imrot_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [imrot_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [imrot_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready
);

  imrot_pkg::cfg_t       cfg;
  imrot_pkg::dp_cmd_t    cmd;
  imrot_pkg::dp_status_t status;

  // Configuration registers
  imrot_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  imrot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Counters, address math, pixel store, output register
  imrot_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Not-ready results carry no pixel and no last flag
  `IMROT_ASSERT(a_nr_clean, (out_valid_o && out_data_o.not_ready) |-> ((out_data_o.pixel_out == '0) && !out_data_o.last_of_image), "not-ready result carries data")
  // A transaction is captured only while the input is not stalled
  `IMROT_ASSERT(a_latch_on_accept, cmd.latch |-> (in_valid_i && !in_stall_o), "capture without acceptance")
  // Pixel bits above the configured width read back as zero
  `IMROT_ASSERT(a_pixel_width, (out_valid_o && !out_data_o.not_ready) |-> ((out_data_o.pixel_out >> PIXEL_BITS) == '0), "pixel wider than configured")

endmodule
